[src/gbm_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gbm_pkg: shared types and constants of the GBM step factor
// Lane structures handed between the cells and the fixed-point constants.
// ---------------------------------------------------------------------------
package gbm_pkg;

  localparam int unsigned SQRT_CELLS = 32;
  localparam int unsigned EXP_CELLS  = 20;

  // ln(2) in unsigned Q.56, and 16*ln(2) as the saturation bound.
  localparam logic [55:0]        LN2_Q56     = 56'hB17217F7D1CF7A;
  localparam logic signed [63:0] SAT_X56     = 64'sh0B17217F7D1CF7A0;
  localparam logic [56:0]        ONE_Q56     = 57'h100_0000_0000_0000;
  // round(2^20 / ln(2)), used to estimate the integer part of x / ln(2).
  localparam logic [20:0]        INV_LN2_Q20 = 21'd1512775;

  typedef enum logic [1:0] {
    OP_PATH      = 2'd0,
    OP_UNDO_PATH = 2'd1,
    OP_LOG       = 2'd2,
    OP_UNDO_LOG  = 2'd3
  } op_t;

  // Square root lane: remainder and partial root.
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_t;

  // Series lane: current term, running sum, the reduced argument, the exponent q and the saturation and zero flags.
  typedef struct packed {
    logic               valid;
    logic [56:0]        term;
    logic [63:0]        sum;
    logic [55:0]        r;
    logic signed [7:0]  q;
    logic               sat;
    logic               zero;
  } exp_lane_t;

endpackage
`default_nettype wire

[src/gbm_sqrt_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gbm_sqrt_cell: one digit of the integer square root
// Trial subtract of root plus the cell's bit, then hands the lane on.
// ---------------------------------------------------------------------------
module gbm_sqrt_cell (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [63:0]   step_bit,
  input  wire gbm_pkg::sqrt_t d_in,
  output gbm_pkg::sqrt_t     d_out
);

  gbm_pkg::sqrt_t d_next;
  logic [63:0]    trial;

  always_comb begin
    trial = d_in.root + step_bit;
    if (d_in.rem >= trial) begin
      d_next.rem  = d_in.rem - trial;
      d_next.root = (d_in.root >> 1) + step_bit;
    end else begin
      d_next.rem  = d_in.rem;
      d_next.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule
`default_nettype wire

[src/gbm_exp_cell.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gbm_exp_cell: one term of the exponential series
// Takes term(n-1), forms round(term*r) / n over four stages and adds the
// incoming term to the running sum. The divide by n is a multiply by
// recip = ceil(2^62 / n), which is exact for 57-bit operands and n < 32.
// ---------------------------------------------------------------------------
module gbm_exp_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic [62:0]        recip,
  input  wire gbm_pkg::exp_lane_t lane_in,
  output gbm_pkg::exp_lane_t      lane_out
);

  gbm_pkg::exp_lane_t st1, st2, st3;
  gbm_pkg::exp_lane_t st1_next, lane_next;
  logic [63:0]  a0, b0, b1;
  logic [55:0]  a1, b3;
  logic [56:0]  a2, b2;
  logic [48:0]  a3;
  logic [56:0]  v;
  logic [112:0] prod1;
  logic [112:0] prod1_rnd;
  logic [120:0] prod2;

  always_comb begin
    prod1 = 113'(a0) + (113'(a1) << 32) + (113'(a2) << 32) + (113'(a3) << 64);
    prod1_rnd = prod1 + (113'(1) << 55);
    prod2 = 121'(b0) + (121'(b1) << 32) + (121'(b2) << 32) + (121'(b3) << 64);
    st1_next     = lane_in;
    st1_next.sum = lane_in.sum + 64'(lane_in.term);
    lane_next      = st3;
    lane_next.term = prod2[118:62];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1.valid      <= 1'b0;
      st2.valid      <= 1'b0;
      st3.valid      <= 1'b0;
      lane_out.valid <= 1'b0;
    end else if (en) begin
      st1       <= st1_next;
      a0        <= lane_in.term[31:0] * lane_in.r[31:0];
      a1        <= lane_in.term[31:0] * lane_in.r[55:32];
      a2        <= lane_in.term[56:32] * lane_in.r[31:0];
      a3        <= lane_in.term[56:32] * lane_in.r[55:32];

      st2       <= st1;
      v         <= prod1_rnd[112:56];

      st3       <= st2;
      b0        <= v[31:0] * recip[31:0];
      b1        <= v[31:0] * recip[62:32];
      b2        <= v[56:32] * recip[31:0];
      b3        <= v[56:32] * recip[62:32];

      lane_out  <= lane_next;
    end
  end

endmodule
`default_nettype wire

[src/gbm_step_factor.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// gbm_step_factor: lognormal growth factor of one GBM step
// Fully pipelined: square root and exponential series built as cell chains.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  cfg      cfg_valid/cfg_ready    cfg_data: drift_rate
//  s        s_tvalid/s_tready      s_tdata: horizon, maturity, vol, draw, lret
//  m        m_tvalid/m_tready      m_tdata: growth_factor, m_tuser: overflow
//
//  One request is taken per cycle while s_tready is high; it passes through
//  32 square root cells, 80 stages in the 20 series cells of four stages
//  each, and the input, term, reduction and output stages. The pipeline
//  keeps moving while one result waits at the output; a second waiting
//  result fills the skid register and then holds s_tready low. Reset
//  clears all valid bits and sets drift_rate to zero.
// ---------------------------------------------------------------------------
module gbm_step_factor (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // horizon_years, maturity_years, volatility, normal_draw, log_return
  input  wire logic [159:0] s_tdata,
  // operation
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // growth_factor
  output logic [63:0]       m_tdata,
  // overflow
  output logic [0:0]        m_tuser
);

  localparam logic signed [49:0] X_HI = 50'sd12 <<< 32;
  localparam logic signed [49:0] X_LO = -(50'sd35 <<< 32);

  typedef struct packed {
    logic        valid;
    logic [1:0]  op;
    logic [31:0] lr;
    logic [31:0] vol;
    logic [31:0] zmag;
    logic        zneg;
    logic        dneg;
    logic [31:0] t;
    logic [63:0] vv;
    logic [63:0] dprod;
  } side_t;

  logic [31:0] drift;
  logic        en;
  logic        skid_valid;
  logic [63:0] skid_factor;
  logic        skid_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      drift <= '0;
    end else if (cfg_valid) begin
      drift <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign en        = !skid_valid;
  assign s_tready  = en;

  // Input capture.
  logic        v0;
  logic [1:0]  op0;
  logic [31:0] h0, mt0, vol0, z0, lr0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0   <= s_tvalid;
      op0  <= s_tuser;
      h0   <= s_tdata[31:0];
      mt0  <= s_tdata[63:32];
      vol0 <= s_tdata[95:64];
      z0   <= s_tdata[127:96];
      lr0  <= s_tdata[159:128];
    end
  end

  // Step length, magnitudes and the first products.
  side_t       side1_next;
  logic [31:0] t0, dmag0;

  always_comb begin
    t0                = (h0 < mt0) ? h0 : mt0;
    dmag0             = drift[31] ? 32'(0 - drift) : drift;
    side1_next.valid  = v0;
    side1_next.op     = op0;
    side1_next.lr     = lr0;
    side1_next.vol    = vol0;
    side1_next.zneg   = z0[31];
    side1_next.zmag   = z0[31] ? 32'(0 - z0) : z0;
    side1_next.dneg   = drift[31];
    side1_next.t      = t0;
    side1_next.vv     = vol0 * vol0;
    side1_next.dprod  = dmag0 * t0;
  end

  side_t          side_d [gbm_pkg::SQRT_CELLS+1];
  gbm_pkg::sqrt_t sq_head;
  gbm_pkg::sqrt_t sq_link [gbm_pkg::SQRT_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= gbm_pkg::SQRT_CELLS; i++) begin
        side_d[i].valid <= 1'b0;
      end
    end else if (en) begin
      side_d[0]    <= side1_next;
      sq_head.rem  <= {t0, 32'b0};
      sq_head.root <= '0;
      for (int i = 0; i < gbm_pkg::SQRT_CELLS; i++) begin
        side_d[i+1] <= side_d[i];
      end
    end
  end

  assign sq_link[0] = sq_head;

  for (genvar i = 0; i < gbm_pkg::SQRT_CELLS; i++) begin : g_sqrt
    localparam logic [63:0] STEP_BIT = 64'd1 << (62 - 2 * i);
    gbm_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .step_bit (STEP_BIT),
      .d_in     (sq_link[i]),
      .d_out    (sq_link[i+1])
    );
  end

  side_t       sd;
  logic [31:0] root;
  assign sd   = side_d[gbm_pkg::SQRT_CELLS];
  assign root = sq_link[gbm_pkg::SQRT_CELLS].root[31:0];

  // Drift, Ito and diffusion terms.
  logic        va, vb, vc, vd, ve;
  logic [1:0]  opa, opb, opc, opd;
  logic [31:0] lra, lrb, lrc, zmaga;
  logic        znega, znegb, zngc, dnega, dnegb, dnegc;
  logic [63:0] vs, hp0, hp1, dzp0, dzp1;
  logic [43:0] dta, dtb, dtc;
  logic [46:0] hvb, hvc;
  logic [43:0] dzc;
  logic [64:0] dt_sum;
  logic [96:0] hv_sum, dz_sum;
  logic signed [49:0] base_d, x_e;
  logic signed [49:0] dt_s, dz_s, path_x, log_x;

  always_comb begin
    dt_sum = 65'(sd.dprod) + (65'(1) << 19);
    hv_sum = 97'(hp0) + (97'(hp1) << 32) + (97'(1) << 48);
    dz_sum = 97'(dzp0) + (97'(dzp1) << 32) + (97'(1) << 51);
    dt_s   = dnegc ? -$signed(50'(dtc)) : $signed(50'(dtc));
    dz_s   = zngc ? -$signed(50'(dzc)) : $signed(50'(dzc));
    path_x = dt_s - $signed(50'(hvc)) + dz_s;
    log_x  = 50'($signed(lrc)) <<< 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else if (en) begin
      va    <= sd.valid;
      opa   <= sd.op;
      lra   <= sd.lr;
      zmaga <= sd.zmag;
      znega <= sd.zneg;
      dnega <= sd.dneg;
      vs    <= sd.vol * root;
      dta   <= dt_sum[63:20];
      hp0   <= sd.vv[31:0] * sd.t;
      hp1   <= sd.vv[63:32] * sd.t;

      vb    <= va;
      opb   <= opa;
      lrb   <= lra;
      znegb <= znega;
      dtb   <= dta;
      dnegb <= dnega;
      dzp0  <= vs[31:0] * zmaga;
      dzp1  <= vs[63:32] * zmaga;
      hvb   <= hv_sum[95:49];

      vc    <= vb;
      opc   <= opb;
      lrc   <= lrb;
      zngc  <= znegb;
      dtc   <= dtb;
      dnegc <= dnegb;
      hvc   <= hvb;
      dzc   <= dz_sum[95:52];

      vd     <= vc;
      opd    <= opc;
      base_d <= (opc == gbm_pkg::OP_LOG || opc == gbm_pkg::OP_UNDO_LOG) ? log_x : path_x;

      ve  <= vd;
      x_e <= (opd == gbm_pkg::OP_UNDO_PATH || opd == gbm_pkg::OP_UNDO_LOG) ? -base_d : base_d;
    end
  end

  // Range reduction: x = q*ln2 + r with r in [0, ln2).
  logic               v1, v2;
  logic               sat1, zero1, sat2, zero2;
  logic signed [63:0] x56_1, rem2;
  logic signed [40:0] qprod1;
  logic signed [7:0]  q2;
  logic signed [64:0] qm;
  logic signed [63:0] ln2_s;
  gbm_pkg::exp_lane_t lane_head;

  assign ln2_s = $signed({8'b0, gbm_pkg::LN2_Q56});
  assign qm    = $signed(qprod1[39:32]) * $signed({1'b0, gbm_pkg::LN2_Q56});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      lane_head.valid <= 1'b0;
    end else if (en) begin
      v1     <= ve;
      sat1   <= x_e >= X_HI;
      zero1  <= x_e < X_LO;
      x56_1  <= 64'($signed(x_e[39:0])) <<< 24;
      qprod1 <= $signed(x_e[38:20]) * $signed({1'b0, gbm_pkg::INV_LN2_Q20});

      // Below the underflow bound the low bits of x mean nothing.
      v2    <= v1;
      sat2  <= sat1 || (!zero1 && (x56_1 >= gbm_pkg::SAT_X56));
      zero2 <= zero1;
      q2    <= $signed(qprod1[39:32]);
      rem2  <= x56_1 - $signed(qm[63:0]);

      lane_head.valid <= v2;
      lane_head.term  <= gbm_pkg::ONE_Q56;
      lane_head.sum   <= '0;
      lane_head.sat   <= sat2;
      lane_head.zero  <= zero2;
      priority if (rem2 < 0) begin
        lane_head.r <= 56'(rem2 + ln2_s);
        lane_head.q <= q2 - 8'sd1;
      end else if (rem2 >= ln2_s) begin
        lane_head.r <= 56'(rem2 - ln2_s);
        lane_head.q <= q2 + 8'sd1;
      end else begin
        lane_head.r <= 56'(rem2);
        lane_head.q <= q2;
      end
    end
  end

  gbm_pkg::exp_lane_t lane_link [gbm_pkg::EXP_CELLS+1];
  assign lane_link[0] = lane_head;

  for (genvar i = 0; i < gbm_pkg::EXP_CELLS; i++) begin : g_exp
    localparam logic [62:0] RECIP = 63'(((64'd1 << 62) + 64'(i)) / 64'(i + 1));
    gbm_exp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .recip    (RECIP),
      .lane_in  (lane_link[i]),
      .lane_out (lane_link[i+1])
    );
  end

  // Final sum and scaling by 2^(q-8) into Q16.48.
  gbm_pkg::exp_lane_t lt;
  logic               vf;
  logic [63:0]        sumf;
  logic signed [7:0]  qf;
  logic               satf, zerof;
  logic               fin_valid;
  logic [63:0]        fin_factor;
  logic               fin_ovf;
  logic [63:0]        res_factor;
  logic               res_ovf;
  logic signed [8:0]  q_up, q_dn;
  logic [64:0]        rnd_sum;

  assign lt = lane_link[gbm_pkg::EXP_CELLS];

  always_comb begin
    q_up       = 9'(qf) - 9'sd8;
    q_dn       = 9'sd8 - 9'(qf);
    rnd_sum    = '0;
    res_factor = '0;
    res_ovf    = 1'b0;
    priority if (satf) begin
      res_factor = '1;
      res_ovf    = 1'b1;
    end else if (zerof) begin
      res_factor = '0;
    end else if (qf > 8'sd8) begin
      if (sumf > ({64{1'b1}} >> q_up[2:0])) begin
        res_factor = '1;
        res_ovf    = 1'b1;
      end else begin
        res_factor = sumf << q_up[2:0];
      end
    end else if (q_dn == 9'sd0) begin
      res_factor = sumf;
    end else begin
      rnd_sum    = (65'(sumf) + (65'(1) << (q_dn[5:0] - 6'd1))) >> q_dn[5:0];
      res_factor = rnd_sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf        <= 1'b0;
      fin_valid <= 1'b0;
    end else if (en) begin
      vf    <= lt.valid;
      sumf  <= lt.sum + 64'(lt.term);
      qf    <= lt.q;
      satf  <= lt.sat;
      zerof <= lt.zero;

      fin_valid  <= vf;
      fin_factor <= res_factor;
      fin_ovf    <= res_ovf;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= skid_factor;
        m_tuser[0] <= skid_ovf;
        skid_valid <= 1'b0;
      end else if (en && fin_valid) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= fin_factor;
        m_tuser[0] <= fin_ovf;
      end else begin
        m_tvalid   <= 1'b0;
      end
    end else if (en && fin_valid) begin
      skid_valid  <= 1'b1;
      skid_factor <= fin_factor;
      skid_ovf    <= fin_ovf;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a result while the output register is empty");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == {64{1'b1}}))
    else $error("overflow flagged without a saturated factor");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && !skid_valid && fin_valid) |=> skid_valid)
    else $error("result dropped while the output was stalled");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed before it was taken");

endmodule
`default_nettype wire

[tb/gbm_step_factor_tb.sv]
// ---------------------------------------------------------------------------
// gbm_step_factor_tb: self-checking bench for the GBM step factor
// Every request is run through a bit-exact fixed-point model of the step
// factor and the exponential. Each result is compared in order against it,
// under random request gaps, output stalls and several drift settings.
// ---------------------------------------------------------------------------
module gbm_step_factor_tb;

  localparam int unsigned PIPE_CYCLES = 130;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic [63:0] growth;
    logic        ovf;
  } factor_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [0:0]   m_tuser;

  factor_t     factor_q[$];
  logic [31:0] drift_shadow = '0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned ovf_seen = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_cnt = 0;
  int unsigned quiet_cycles = 0;

  gbm_step_factor dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- fixed-point predictor ----------------------------------------------

  function automatic logic [63:0] mul_round_shift(logic [63:0] a, logic [63:0] b,
                                                  int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    return p[63 + sh -: 64];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] magnitude32(logic [31:0] raw, output logic neg);
    neg = raw[31];
    return neg ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
  endfunction

  function automatic factor_t exp_q48(longint x32);
    factor_t     f;
    longint      ln2;
    longint      x56;
    longint      q;
    longint      rem;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] sum;
    int unsigned s;
    ln2 = longint'({8'd0, gbm_pkg::LN2_Q56});
    f.ovf = 1'b0;
    f.growth = '1;
    if (x32 >= (longint'(12) <<< 32)) begin
      f.ovf = 1'b1;
      return f;
    end
    if (x32 < -(longint'(35) <<< 32)) begin
      f.growth = '0;
      return f;
    end
    x56 = x32 * longint'(64'd16777216);
    if (x56 >= 16 * ln2) begin
      f.ovf = 1'b1;
      return f;
    end
    q = x56 / ln2;
    rem = x56 - q * ln2;
    if (rem < 0) begin
      rem = rem + ln2;
      q = q - 1;
    end
    r = rem;
    term = 64'd1 << 56;
    sum = term;
    for (int n = 1; n <= 40; n++) begin
      term = mul_round_shift(term, r, 56) / n;
      if (term == 0) break;
      sum = sum + term;
    end
    if (q > 8) begin
      s = 32'(q - 8);
      if (sum > ({64{1'b1}} >> s)) begin
        f.ovf = 1'b1;
        return f;
      end
      f.growth = sum << s;
    end else begin
      s = 32'(8 - q);
      f.growth = (s == 0) ? sum : (sum + (64'd1 << (s - 1))) >> s;
    end
    return f;
  endfunction

  function automatic factor_t predict_factor(gbm_pkg::op_t op, logic [31:0] horizon,
      logic [31:0] maturity, logic [31:0] vol, logic [31:0] draw, logic [31:0] lret);
    longint      x;
    logic        dneg, zneg, lneg;
    logic [63:0] t, dmag, zmag, lmag, dt, hv, sq, dz;
    if (op == gbm_pkg::OP_LOG || op == gbm_pkg::OP_UNDO_LOG) begin
      lmag = magnitude32(lret, lneg);
      x = longint'(lmag << 8);
      if (lneg) x = -x;
    end else begin
      t = (horizon < maturity) ? {32'd0, horizon} : {32'd0, maturity};
      dmag = magnitude32(drift_shadow, dneg);
      zmag = magnitude32(draw, zneg);
      dt = mul_round_shift(dmag, t, 20);
      hv = mul_round_shift({32'd0, vol} * {32'd0, vol}, t, 49);
      sq = root_floor(t << 32);
      dz = mul_round_shift({32'd0, vol} * sq, zmag, 52);
      x = dneg ? -longint'(dt) : longint'(dt);
      x = x - longint'(hv);
      x = x + (zneg ? -longint'(dz) : longint'(dz));
    end
    if (op == gbm_pkg::OP_UNDO_PATH || op == gbm_pkg::OP_UNDO_LOG) x = -x;
    return exp_q48(x);
  endfunction

  // ---- checking -------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("ERROR result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (factor_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        factor_t want;
        want = factor_q.pop_front();
        if (m_tdata !== want.growth) report_mismatch("growth_factor", m_tdata, want.growth);
        if (m_tuser[0] !== want.ovf) begin
          report_mismatch("overflow", 64'(m_tuser[0]), 64'(want.ovf));
        end
        if (want.ovf) ovf_seen++;
      end
      results_seen++;
    end
  end

  // Output back-pressure: always ready, random, or a fixed periodic pattern.
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) < 6);
      default: m_tready <= ((stall_cnt % 13) > 4);
    endcase
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
        || (factor_q.size() == 0 && !s_tvalid && !cfg_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR no progress for %0d cycles", STALL_LIMIT);
      $display("gbm_step_factor: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- drivers --------------------------------------------------------------

  task automatic send_request(gbm_pkg::op_t op, logic [31:0] horizon,
      logic [31:0] maturity, logic [31:0] vol, logic [31:0] draw, logic [31:0] lret);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {lret, draw, vol, maturity, horizon};
    do @(posedge clk); while (!s_tready);
    factor_q.push_back(predict_factor(op, horizon, maturity, vol, draw, lret));
    requests_sent++;
    burst_left--;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (factor_q.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic write_drift(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    drift_shadow = value;
  endtask

  // ---- tests ----------------------------------------------------------------

  task automatic test_directed();
    logic [31:0] one_year;
    one_year = 32'h0100_0000;
    send_request(gbm_pkg::OP_PATH, 32'd0, one_year, 32'h1000_0000, 32'h1000_0000, 32'd0);
    send_request(gbm_pkg::OP_UNDO_PATH, one_year, 32'd0, 32'h0400_0000, 32'hF000_0000,
                 32'd0);
    send_request(gbm_pkg::OP_PATH, one_year, 32'h0200_0000, 32'h0333_3333, 32'h1000_0000,
                 32'd0);
    send_request(gbm_pkg::OP_UNDO_PATH, 32'h0200_0000, one_year, 32'h0333_3333,
                 32'hE000_0000, 32'd0);
    send_request(gbm_pkg::OP_PATH, '1, '1, '1, 32'h7FFF_FFFF, 32'd0);
    send_request(gbm_pkg::OP_PATH, '1, '1, '1, 32'h8000_0000, 32'd0);
    send_request(gbm_pkg::OP_UNDO_PATH, '1, '1, 32'd0, 32'd0, 32'd0);
    send_request(gbm_pkg::OP_PATH, one_year, one_year, '1, 32'd0, 32'd0);
    send_request(gbm_pkg::OP_LOG, '1, '1, '1, '1, 32'd0);
    send_request(gbm_pkg::OP_UNDO_LOG, '0, '0, '0, '0, 32'd0);
    send_request(gbm_pkg::OP_LOG, 0, 0, 0, 0, 32'h7FFF_FFFF);
    send_request(gbm_pkg::OP_LOG, 0, 0, 0, 0, 32'h8000_0000);
    send_request(gbm_pkg::OP_UNDO_LOG, 0, 0, 0, 0, 32'h7FFF_FFFF);
    send_request(gbm_pkg::OP_UNDO_LOG, 0, 0, 0, 0, 32'h8000_0000);
    // Around the saturation bound of sixteen times ln 2.
    send_request(gbm_pkg::OP_LOG, 0, 0, 0, 0, 32'h0B17_217F);
    send_request(gbm_pkg::OP_LOG, 0, 0, 0, 0, 32'h0B17_2180);
    send_request(gbm_pkg::OP_UNDO_LOG, 0, 0, 0, 0, 32'hF4E8_DE81);
    // Around the underflow bound at an exponent of minus 35.
    send_request(gbm_pkg::OP_LOG, 0, 0, 0, 0, 32'hDD00_0000);
    send_request(gbm_pkg::OP_LOG, 0, 0, 0, 0, 32'hDCFF_FFFF);
    send_request(gbm_pkg::OP_UNDO_LOG, 0, 0, 0, 0, 32'h2300_0001);
    send_request(gbm_pkg::OP_LOG, 0, 0, 0, 0, 32'h0C00_0000);
    send_request(gbm_pkg::OP_LOG, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_request(gbm_pkg::OP_UNDO_LOG, 0, 0, 0, 0, 32'h0000_0001);
    wait_drained();
  endtask

  task automatic test_random(int unsigned count);
    gbm_pkg::op_t op;
    logic [31:0]  h, m, v, z, l;
    for (int unsigned i = 0; i < count; i++) begin
      op = gbm_pkg::op_t'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        h = $urandom; m = $urandom; v = $urandom; z = $urandom; l = $urandom;
      end else begin
        // Typical market values: a few years, moderate vol, draws within 3 sigma.
        h = $urandom_range(0, 32'h0400_0000);
        m = $urandom_range(0, 32'h0400_0000);
        v = $urandom_range(0, 32'h1800_0000);
        z = $urandom_range(0, 32'h6000_0000) - 32'h3000_0000;
        l = $urandom_range(0, 32'h1800_0000) - 32'h0C00_0000;
      end
      send_request(op, h, m, v, z, l);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    stall_mode = 0;
    test_directed();
    write_drift(32'h7FFF_FFFF);
    stall_mode = 1;
    test_directed();
    test_random(500);
    write_drift(32'h8000_0000);
    stall_mode = 2;
    test_directed();
    test_random(500);
    write_drift(32'd0);
    stall_mode = 0;
    test_random(500);
    write_drift($urandom_range(0, 32'h0800_0000) - 32'h0400_0000);
    stall_mode = 1;
    test_random(500);
    $display("Sent %0d requests over four drift settings and three stall patterns;",
             requests_sent);
    $display("checked %0d results, %0d of them saturated.", results_seen, ovf_seen);
    if (mismatches == 0 && factor_q.size() == 0) begin
      $display("gbm_step_factor: match");
    end else begin
      $display("gbm_step_factor: mismatch");
    end
    $finish;
  end

endmodule
